/* hw/rtl/llts_pkg.sv */
// shared types and constants of the least-laxity tick scheduler
`timescale 1ns / 1ps
package llts_pkg;

  // item kinds carried in the input tuser bit
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  localparam int unsigned MAX_TASKS_DEF = 8;
  localparam int unsigned TIME_BITS_DEF = 16;

  localparam logic [3:0]  TASK_COUNT_RST = 4'd8;
  localparam logic [15:0] JOB_MAX        = 16'hFFFF;

  // strobes broadcast from the sequencer to every cell
  typedef struct packed {
    logic load;    // load item transfer this cycle
    logic commit;  // apply the tick update this cycle
  } cell_cmd_t;

endpackage

/* hw/rtl/llts_cell.sv */
// one task slot: its state, its tick update and one stage of the laxity compare chain
`timescale 1ns / 1ps
module llts_cell #(
  parameter int unsigned TIME_BITS = llts_pkg::TIME_BITS_DEF,
  parameter int unsigned IDX_W     = 3,
  parameter int unsigned IDX       = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  llts_pkg::cell_cmd_t    cmd_i,
  input  logic                   slot_hit_i,
  input  logic                   active_i,
  input  logic                   run_hit_i,
  input  logic [TIME_BITS-1:0]   exec_i,
  input  logic [TIME_BITS-1:0]   period_i,
  input  logic [TIME_BITS-1:0]   deadline_i,
  input  logic                   c_found_i,
  input  logic signed [TIME_BITS+1:0] c_lax_i,
  input  logic [IDX_W-1:0]       c_sel_i,
  output logic                   c_found_o,
  output logic signed [TIME_BITS+1:0] c_lax_o,
  output logic [IDX_W-1:0]       c_sel_o,
  output logic                   miss_o,
  output logic [15:0]            job_next_o
);
  import llts_pkg::*;

  localparam logic [TIME_BITS:0] DL_FLOOR = {1'b1, {TIME_BITS{1'b0}}};

  logic [TIME_BITS-1:0] exec_q, exec_d;
  logic [TIME_BITS-1:0] per_q, per_d;
  logic [TIME_BITS-1:0] dln_q, dln_d;
  logic [TIME_BITS-1:0] work_q, work_d;
  logic [TIME_BITS:0]   pc_q, pc_d;
  logic [TIME_BITS:0]   dl_q, dl_d;
  logic [15:0]          job_q, job_d;

  logic                 c_found_q, c_found_d;
  logic signed [TIME_BITS+1:0] c_lax_q, c_lax_d;
  logic [IDX_W-1:0]     c_sel_q, c_sel_d;

  logic signed [TIME_BITS+1:0] lax;
  logic [TIME_BITS-1:0] work_run;
  logic [TIME_BITS:0]   dl_dec;
  logic                 reload;
  logic [TIME_BITS:0]   p_start;
  logic [TIME_BITS:0]   in_start;

  // laxity: deadline countdown minus remaining work
  assign lax = $signed({dl_q[TIME_BITS], dl_q}) - $signed({2'b00, work_q});

  always_comb begin
    c_found_d = c_found_i;
    c_lax_d   = c_lax_i;
    c_sel_d   = c_sel_i;
    if (active_i && (work_q != '0) && (!c_found_i || (lax < c_lax_i))) begin
      c_found_d = 1'b1;
      c_lax_d   = lax;
      c_sel_d   = IDX_W'(IDX);
    end
  end

  // zero period counts as one
  assign p_start  = (per_q == '0) ? (TIME_BITS+1)'(1) : {1'b0, per_q};
  assign in_start = (period_i == '0) ? (TIME_BITS+1)'(1) : {1'b0, period_i};

  assign work_run = run_hit_i ? (work_q - TIME_BITS'(1)) : work_q;
  assign reload   = (pc_q[TIME_BITS:1] == '0);
  assign dl_dec   = (dl_q != DL_FLOOR) ? (dl_q - (TIME_BITS+1)'(1)) : dl_q;
  assign miss_o   = active_i && (dl_dec[TIME_BITS] || (dl_dec == '0)) && (work_run != '0);

  always_comb begin
    exec_d = exec_q;
    per_d  = per_q;
    dln_d  = dln_q;
    work_d = work_q;
    pc_d   = pc_q;
    dl_d   = dl_q;
    job_d  = job_q;
    if (cmd_i.load && slot_hit_i) begin
      exec_d = exec_i;
      per_d  = period_i;
      dln_d  = deadline_i;
      work_d = exec_i;
      pc_d   = in_start;
      dl_d   = {1'b0, deadline_i};
      job_d  = 16'd1;
    end else if (cmd_i.commit && active_i) begin
      if (reload) begin
        work_d = exec_q;
        pc_d   = p_start;
        dl_d   = {1'b0, dln_q};
        if (job_q != JOB_MAX) begin
          job_d = job_q + 16'd1;
        end
      end else begin
        work_d = work_run;
        pc_d   = pc_q - (TIME_BITS+1)'(1);
        dl_d   = dl_dec;
      end
    end
  end

  assign job_next_o = job_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q    <= '0;
      per_q     <= '0;
      dln_q     <= '0;
      work_q    <= '0;
      pc_q      <= '0;
      dl_q      <= '0;
      job_q     <= 16'd1;
      c_found_q <= 1'b0;
    end else begin
      exec_q    <= exec_d;
      per_q     <= per_d;
      dln_q     <= dln_d;
      work_q    <= work_d;
      pc_q      <= pc_d;
      dl_q      <= dl_d;
      job_q     <= job_d;
      c_found_q <= c_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_lax_q <= c_lax_d;
    c_sel_q <= c_sel_d;
  end

  assign c_found_o = c_found_q;
  assign c_lax_o   = c_lax_q;
  assign c_sel_o   = c_sel_q;

endmodule

/* hw/rtl/least_laxity_tick_scheduler.sv */
// top level of the least-laxity-first periodic tick scheduler
`timescale 1ns / 1ps
// usage
//   s_axis: one item per transfer; tuser = func (0 tick, 1 load), tdata holds
//   the slot and the job parameters of a load (ignored by a tick)
//   m_axis: one result per tick, none per load; tuser = run_valid, tdata holds
//   run_task, run_job and miss_mask
//   cfg: one write channel for task_count, taken only while no item is in flight
// sequence
//   a load updates its slot as it transfers and the next item may follow
//   right after it; a tick moves the sequencer into its walk state, where the
//   laxity compare wave crosses the row of cells one cell per cycle, then into
//   its commit state, which updates every active slot at once and loads the
//   result register; the next item is taken only once the sequencer is back in idle
// reset
//   all slots clear with job number 1, task_count returns to 8, no result pending
// stall
//   while a result waits in the output register the next item is still taken;
//   a following tick holds in its commit cycle until the old result transfers
module least_laxity_tick_scheduler #(
  parameter int unsigned MAX_TASKS = llts_pkg::MAX_TASKS_DEF,
  parameter int unsigned TIME_BITS = llts_pkg::TIME_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] task_slot, [18:3] exec_time, [34:19] period_len, [50:35] rel_deadline
  input  logic [55:0] s_axis_tdata,
  // [0] func
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] run_task, [18:3] run_job, [26:19] miss_mask
  output logic [31:0] m_axis_tdata,
  // [0] run_valid
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);
  import llts_pkg::*;

  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [3:0]       task_count_q;

  logic             in_xfer;
  logic             commit;
  cell_cmd_t        cmd;

  logic [2:0]           s_slot;
  logic [TIME_BITS-1:0] s_exec, s_period, s_deadline;

  // compare chain: entry k feeds cell k, entry MAX_TASKS is the winner
  logic                        ch_found [MAX_TASKS+1];
  logic signed [TIME_BITS+1:0] ch_lax   [MAX_TASKS+1];
  logic [IDX_W-1:0]            ch_sel   [MAX_TASKS+1];

  logic [MAX_TASKS-1:0] slot_hit, active, run_hit, miss;
  logic [15:0]          job_next [MAX_TASKS];
  logic [7:0]           miss_mask;

  logic        out_valid_q, out_valid_d;
  logic        run_valid_q;
  logic [2:0]  run_task_q;
  logic [15:0] run_job_q;
  logic [7:0]  miss_mask_q;

  // input fields, masked or widened to the time width
  assign s_slot     = s_axis_tdata[2:0];
  assign s_exec     = TIME_BITS'(s_axis_tdata[18:3]);
  assign s_period   = TIME_BITS'(s_axis_tdata[34:19]);
  assign s_deadline = TIME_BITS'(s_axis_tdata[50:35]);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // commit only when the output register is free or frees this cycle
  assign commit = (state_q == ST_COMMIT) && (!out_valid_q || m_axis_tready);

  assign cmd.load   = in_xfer && (s_axis_tuser == FUNC_LOAD);
  assign cmd.commit = commit;

  // head of the chain: nothing found yet
  assign ch_found[0] = 1'b0;
  assign ch_lax[0]   = '0;
  assign ch_sel[0]   = '0;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    // slots from 8 up cannot be loaded
    if (i < 8) begin : g_load
      assign slot_hit[i] = (s_slot == 3'(i));
    end else begin : g_noload
      assign slot_hit[i] = 1'b0;
    end
    // a count above the slot number saturates naturally
    assign active[i]  = (7'(i) < {3'b000, task_count_q});
    assign run_hit[i] = commit && ch_found[MAX_TASKS] && (ch_sel[MAX_TASKS] == IDX_W'(i));

    llts_cell #(
      .TIME_BITS (TIME_BITS),
      .IDX_W     (IDX_W),
      .IDX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .slot_hit_i (slot_hit[i]),
      .active_i   (active[i]),
      .run_hit_i  (run_hit[i]),
      .exec_i     (s_exec),
      .period_i   (s_period),
      .deadline_i (s_deadline),
      .c_found_i  (ch_found[i]),
      .c_lax_i    (ch_lax[i]),
      .c_sel_i    (ch_sel[i]),
      .c_found_o  (ch_found[i+1]),
      .c_lax_o    (ch_lax[i+1]),
      .c_sel_o    (ch_sel[i+1]),
      .miss_o     (miss[i]),
      .job_next_o (job_next[i])
    );
  end

  // only the first eight slots report misses
  for (genvar b = 0; b < 8; b++) begin : g_miss
    if (b < MAX_TASKS) begin : g_have
      assign miss_mask[b] = miss[b];
    end else begin : g_none
      assign miss_mask[b] = 1'b0;
    end
  end

  // sequencer: a tick waits in the walk state for the compare wave, then commits
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (s_axis_tuser == FUNC_TICK)) begin
          state_d = ST_WALK;
          cnt_d   = '0;
        end
      end
      ST_WALK: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MAX_TASKS - 1)) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      task_count_q <= TASK_COUNT_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        task_count_q <= cfg_data_i;
      end
    end
  end

  // result register, an idle tick reports zero slot and job
  always_ff @(posedge clk_i) begin
    if (commit) begin
      run_valid_q <= ch_found[MAX_TASKS];
      run_task_q  <= ch_found[MAX_TASKS] ? 3'(ch_sel[MAX_TASKS]) : 3'd0;
      run_job_q   <= ch_found[MAX_TASKS] ? job_next[ch_sel[MAX_TASKS]] : 16'd0;
      miss_mask_q <= miss_mask;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = run_valid_q;
  assign m_axis_tdata  = {5'b00000, miss_mask_q, run_job_q, run_task_q};

  // a result appears only out of a commit cycle
  a_rise_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_COMMIT))
    else $error("result appeared without a commit");

  // an idle tick carries zero slot and job
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[18:0] == 19'd0))
    else $error("idle result with nonzero slot or job");

  // a stalled old result holds the commit back
  a_commit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT && m_axis_tvalid && !m_axis_tready) |=> (state_q == ST_COMMIT))
    else $error("commit overran a pending result");

  // no item taken in the walk step that follows the zero count
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |=> !(s_axis_tvalid && s_axis_tready && $past(cnt_q) == '0 && state_q == ST_WALK))
    else $error("item taken during the compare walk");

endmodule

/* verif/llts_schedule_checker.sv */
// watches the scheduler channels, predicts each tick's result and compares
`timescale 1ns / 1ps
module llts_schedule_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  import llts_pkg::*;

  localparam int unsigned SLOTS = MAX_TASKS_DEF;
  localparam logic signed [16:0] DEADLINE_FLOOR = {1'b1, 16'h0000};

  typedef struct packed {
    logic        run_valid;
    logic [2:0]  run_task;
    logic [15:0] run_job;
    logic [7:0]  miss_mask;
  } run_result_t;

  // scheduler state as this side sees it
  logic [3:0]         active_slots;
  logic [15:0]        exec_cfg     [SLOTS];
  logic [15:0]        period_cfg   [SLOTS];
  logic [15:0]        deadline_cfg [SLOTS];
  logic [15:0]        work_rem     [SLOTS];
  logic [16:0]        period_cnt   [SLOTS];
  logic signed [16:0] deadline_cnt [SLOTS];
  logic [15:0]        job_num      [SLOTS];

  run_result_t expected_runs[$];
  int unsigned result_no;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t result %0d: %s got %0d expected %0d", $time, result_no, what, got, want);
    errors_o++;
  endtask

  // a zero period behaves as one
  function automatic logic [16:0] first_countdown(logic [15:0] len);
    return (len == 16'd0) ? 17'd1 : {1'b0, len};
  endfunction

  function automatic void apply_load(logic [55:0] d);
    logic [2:0] s;
    s = d[2:0];
    exec_cfg[s]     = d[18:3];
    period_cfg[s]   = d[34:19];
    deadline_cfg[s] = d[50:35];
    work_rem[s]     = d[18:3];
    period_cnt[s]   = first_countdown(d[34:19]);
    deadline_cnt[s] = signed'({1'b0, d[50:35]});
    job_num[s]      = 16'd1;
  endfunction

  // least laxity pick, one unit of work, countdowns, misses and reloads
  function automatic run_result_t apply_tick();
    run_result_t r;
    bit          found;
    bit          reload;
    int          best;
    int          lax;
    int unsigned n;
    int unsigned pick;
    int unsigned i;
    n     = (active_slots > SLOTS) ? SLOTS : active_slots;
    found = 1'b0;
    best  = 0;
    pick  = 0;
    r     = '0;
    for (i = 0; i < n; i++) begin
      if (work_rem[i] != 16'd0) begin
        lax = int'(deadline_cnt[i]) - int'(work_rem[i]);
        if (!found || lax < best) begin
          found = 1'b1;
          best  = lax;
          pick  = i;
        end
      end
    end
    if (found) work_rem[pick] = work_rem[pick] - 16'd1;
    for (i = 0; i < n; i++) begin
      if (period_cnt[i] <= 17'd1) begin
        period_cnt[i] = '0;
        reload = 1'b1;
      end else begin
        period_cnt[i] = period_cnt[i] - 17'd1;
        reload = 1'b0;
      end
      if (deadline_cnt[i] != DEADLINE_FLOOR) deadline_cnt[i] = deadline_cnt[i] - 17'sd1;
      if (deadline_cnt[i] <= 0 && work_rem[i] != 16'd0) r.miss_mask[i] = 1'b1;
      if (reload) begin
        work_rem[i]     = exec_cfg[i];
        period_cnt[i]   = first_countdown(period_cfg[i]);
        deadline_cnt[i] = signed'({1'b0, deadline_cfg[i]});
        if (job_num[i] != JOB_MAX) job_num[i] = job_num[i] + 16'd1;
      end
    end
    if (found) begin
      r.run_valid = 1'b1;
      r.run_task  = pick[2:0];
      r.run_job   = job_num[pick];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    run_result_t want;
    if (!rst_ni) begin
      active_slots = TASK_COUNT_RST;
      for (int k = 0; k < SLOTS; k++) begin
        exec_cfg[k]     = '0;
        period_cfg[k]   = '0;
        deadline_cfg[k] = '0;
        work_rem[k]     = '0;
        period_cnt[k]   = '0;
        deadline_cnt[k] = '0;
        job_num[k]      = 16'd1;
      end
      expected_runs.delete();
      result_no = 0;
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) active_slots = cfg_data_i;
      // older results leave before a new tick is predicted
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_runs.size() == 0) begin
          report_mismatch("unexpected result, tdata", m_axis_tdata, 0);
        end else begin
          want = expected_runs.pop_front();
          if (m_axis_tuser != want.run_valid)
            report_mismatch("run_valid", m_axis_tuser, want.run_valid);
          if (m_axis_tdata[2:0] != want.run_task)
            report_mismatch("run_task", m_axis_tdata[2:0], want.run_task);
          if (m_axis_tdata[18:3] != want.run_job)
            report_mismatch("run_job", m_axis_tdata[18:3], want.run_job);
          if (m_axis_tdata[26:19] != want.miss_mask)
            report_mismatch("miss_mask", m_axis_tdata[26:19], want.miss_mask);
        end
        result_no++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == FUNC_LOAD) apply_load(s_axis_tdata);
        else expected_runs.push_back(apply_tick());
      end
      pending_o = expected_runs.size();
    end
  end

endmodule

/* verif/tb_least_laxity_tick_scheduler.sv */
// stimulus and verdict for the least-laxity tick scheduler
`timescale 1ns / 1ps
module tb_least_laxity_tick_scheduler;
  import llts_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int IDLE_SETTLE  = 16;
  localparam int PHASE_ITEMS  = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [2:0] task_slot, [18:3] exec_time, [34:19] period_len, [50:35] rel_deadline
  logic [55:0] s_axis_tdata = '0;
  // [0] func
  logic        s_axis_tuser = FUNC_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [2:0] run_task, [18:3] run_job, [26:19] miss_mask
  logic [31:0] m_axis_tdata;
  // [0] run_valid
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i = '0;

  int  errors;
  int  pending;
  int  cycle_cnt = 0;
  int  rx_hold = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  least_laxity_tick_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  llts_schedule_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  // idle length: mostly none, often short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // job parameters: mostly small so that reloads, misses and ties happen often
  function automatic logic [55:0] pack_load(logic [2:0] slot);
    logic [15:0] e, p, d;
    if ($urandom_range(9) == 0) begin
      e = 16'($urandom);
      p = 16'($urandom);
      d = 16'($urandom);
    end else begin
      e = 16'($urandom_range(6));
      p = 16'($urandom_range(14));
      d = 16'($urandom_range(16));
    end
    return {5'b0, d, p, e, slot};
  endfunction

  // a tick ignores its tdata, so it carries random bits
  function automatic logic [55:0] junk_payload();
    return {5'b0, 19'($urandom), 32'($urandom)};
  endfunction

  // receiver stalls, driven on the falling edge
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_calm) rx_hold <= pick_gap();
    end
  end

  // one input transfer; tvalid stays high afterwards until the next call or a drop
  task automatic send_item(logic func, logic [55:0] payload);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= payload;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic load_job(logic [2:0] slot, logic [15:0] e, logic [15:0] p, logic [15:0] d);
    send_item(FUNC_LOAD, {5'b0, d, p, e, slot});
  endtask

  // stop sending and let every expected result come back
  task automatic drain();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // task_count only changes with the block idle
  task automatic write_task_count(logic [3:0] value);
    drain();
    repeat (IDLE_SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  // run ends on the cycle limit if the scheduler hangs
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("[least_laxity_tick_scheduler] ERROR");
    $finish;
  end

  initial begin
    logic [3:0] phase_count [6];
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: nothing loaded yet, so the first tick is idle
    send_item(FUNC_TICK, junk_payload());
    load_job(3'd0, 16'd3, 16'd5, 16'd4);
    load_job(3'd2, 16'd3, 16'd5, 16'd4);          // equal laxity with slot 0
    load_job(3'd1, 16'd2, 16'd4, 16'd1);          // deadline too tight, misses
    load_job(3'd3, 16'd0, 16'd0, 16'd0);          // zero period, reloads each tick
    load_job(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF); // widest job
    load_job(3'd4, 16'd1, 16'd0, 16'd0);          // zero period with work left
    repeat (10) send_item(FUNC_TICK, junk_payload());
    load_job(3'd7, 16'd0, 16'd1, 16'd0);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_TICK, {5'b0, {51{1'b1}}});

    // above MAX_TASKS saturates, then single slot, none, partial, random, full
    phase_count = '{4'd15, 4'd1, 4'd0, 4'd3, 4'($urandom_range(14, 2)), 4'd8};
    for (int ph = 0; ph < 6; ph++) begin
      write_task_count(phase_count[ph]);
      tx_calm = (ph == 2);
      rx_calm = (ph == 2) || (ph == 4);
      // fresh job set first, then mostly ticks with the odd reload of a slot
      for (int s = 0; s < 8; s++) send_item(FUNC_LOAD, pack_load(3'(s)));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) drain();
        if ($urandom_range(99) < 12) send_item(FUNC_LOAD, pack_load(3'($urandom_range(7))));
        else send_item(FUNC_TICK, junk_payload());
      end
    end

    drain();
    repeat (IDLE_SETTLE * 2) @(posedge clk_i);
    if (errors == 0) begin
      $display("[least_laxity_tick_scheduler] OK");
    end else begin
      $display("[least_laxity_tick_scheduler] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/llts_pkg.sv
hw/rtl/llts_cell.sv
hw/rtl/least_laxity_tick_scheduler.sv
verif/llts_schedule_checker.sv
verif/tb_least_laxity_tick_scheduler.sv
